/* rtl/ddc_pkg.sv */
// ----------------------------------------------------------------------------
// ddc_pkg
// Types and constants shared by the dialed digit collector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ddc_pkg;

	// field widths
	localparam int CNT_W     = 6;
	localparam int NUM_W     = 24;
	localparam int CODE_W    = 7;
	localparam int DIGIT_W   = 4;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;

	// digit codes
	localparam logic [DIGIT_W-1:0] CODE_ONE  = 4'd1;
	localparam logic [DIGIT_W-1:0] CODE_ZERO = 4'd10;
	localparam logic [DIGIT_W-1:0] CODE_STAR = 4'd11;
	localparam logic [DIGIT_W-1:0] CODE_HASH = 4'd12;

	// request kinds
	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// outcomes
	localparam logic [1:0] OUT_OK       = 2'd0;
	localparam logic [1:0] OUT_COMPLETE = 2'd1;
	localparam logic [1:0] OUT_ILLEGAL  = 2'd2;
	localparam logic [1:0] OUT_OVERFLOW = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DN_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DN_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SC_MIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SC_MAX = 2'd3;

	// configuration reset values
	localparam logic [NUM_W-1:0]  DN_MIN_RST = 24'd0;
	localparam logic [NUM_W-1:0]  DN_MAX_RST = 24'd9999999;
	localparam logic [CODE_W-1:0] SC_MIN_RST = 7'd0;
	localparam logic [CODE_W-1:0] SC_MAX_RST = 7'd99;

	// queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;
	localparam int FIFO_CNT_W = 2;

	typedef struct packed {
		logic               kind;
		logic [DIGIT_W-1:0] digit_code;
	} ddc_in_t;

	typedef struct packed {
		logic [1:0]        outcome;
		logic [CNT_W-1:0]  digit_count;
		logic              address_complete;
		logic              number_valid;
		logic [NUM_W-1:0]  number_value;
		logic              code_valid;
		logic [CODE_W-1:0] code_value;
	} ddc_out_t;

	// classified request, handed from front to back
	typedef struct packed {
		logic [1:0]        outcome;
		logic [CNT_W-1:0]  digit_count;
		logic              address_complete;
		logic              number_ok;
		logic [NUM_W-1:0]  number_accum;
		logic              code_ok;
		logic [CODE_W-1:0] code_accum;
	} ddc_rec_t;

endpackage

`default_nettype wire

/* rtl/ddc_front.sv */
// ----------------------------------------------------------------------------
// ddc_front
// Accepts digit requests, updates the collection state and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_front #(
	parameter int MAX_DIGITS    = 32,
	parameter int NUMBER_DIGITS = 7,
	parameter int CODE_DIGITS   = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire ddc_pkg::ddc_in_t  req,
	output ddc_pkg::ddc_rec_t      rec
);

	localparam logic [ddc_pkg::CNT_W-1:0] MAX_CNT  = ddc_pkg::CNT_W'(MAX_DIGITS);
	localparam logic [ddc_pkg::CNT_W-1:0] NUM_CNT  = ddc_pkg::CNT_W'(NUMBER_DIGITS);
	localparam logic [ddc_pkg::CNT_W-1:0] CODE_CNT = ddc_pkg::CNT_W'(CODE_DIGITS);

	logic [ddc_pkg::CNT_W-1:0]   cnt_q, cnt_n;
	logic [ddc_pkg::DIGIT_W-1:0] first_q, first_n;
	logic                        hash_q, hash_n;
	logic [ddc_pkg::NUM_W-1:0]   num_q, num_n;
	logic                        num_ok_q, num_ok_n;
	logic [ddc_pkg::CODE_W-1:0]  code_q, code_n;
	logic                        code_ok_q, code_ok_n;

	logic [1:0]                  outcome;
	logic                        is_dec;
	logic [ddc_pkg::DIGIT_W-1:0] dval;
	logic [ddc_pkg::DIGIT_W-1:0] d;
	logic [ddc_pkg::CNT_W-1:0]   size;
	logic                        complete;

	assign d      = req.digit_code;
	assign is_dec = (d >= ddc_pkg::CODE_ONE) && (d <= ddc_pkg::CODE_ZERO);
	assign dval   = (d == ddc_pkg::CODE_ZERO) ? '0 : d;

	always_comb begin
		cnt_n     = cnt_q;
		first_n   = first_q;
		hash_n    = hash_q;
		num_n     = num_q;
		num_ok_n  = num_ok_q;
		code_n    = code_q;
		code_ok_n = code_ok_q;
		outcome   = ddc_pkg::OUT_OK;
		if (req.kind == ddc_pkg::KIND_CLEAR) begin
			cnt_n     = '0;
			first_n   = '0;
			hash_n    = 1'b0;
			num_n     = '0;
			num_ok_n  = 1'b1;
			code_n    = '0;
			code_ok_n = 1'b1;
		end else if (hash_q) begin
			outcome = ddc_pkg::OUT_COMPLETE;
		end else if (d < ddc_pkg::CODE_ONE || d > ddc_pkg::CODE_HASH) begin
			outcome = ddc_pkg::OUT_ILLEGAL;
		end else if (cnt_q >= MAX_CNT) begin
			outcome = ddc_pkg::OUT_OVERFLOW;
		end else begin
			if (cnt_q == '0) begin
				first_n = d;
			end
			if (cnt_q < NUM_CNT) begin
				if (is_dec) begin
					// times ten as two shifts and an add
					num_n = {num_q[ddc_pkg::NUM_W-4:0], 3'b000}
						+ {num_q[ddc_pkg::NUM_W-2:0], 1'b0}
						+ ddc_pkg::NUM_W'(dval);
				end else begin
					num_ok_n = 1'b0;
				end
			end
			if (cnt_q == '0) begin
				if (d != ddc_pkg::CODE_STAR) begin
					code_ok_n = 1'b0;
				end
			end else if (cnt_q < CODE_CNT) begin
				if (is_dec) begin
					code_n = {code_q[ddc_pkg::CODE_W-4:0], 3'b000}
						+ {code_q[ddc_pkg::CODE_W-2:0], 1'b0}
						+ ddc_pkg::CODE_W'(dval);
				end else begin
					code_ok_n = 1'b0;
				end
			end
			cnt_n = cnt_q + ddc_pkg::CNT_W'(1);
			if (d == ddc_pkg::CODE_HASH) begin
				hash_n  = 1'b1;
				outcome = ddc_pkg::OUT_COMPLETE;
			end
		end
	end

	// a trailing hash is not counted
	assign size = cnt_n - ddc_pkg::CNT_W'(hash_n);

	always_comb begin
		if (cnt_n == '0) begin
			complete = 1'b0;
		end else if (hash_n) begin
			complete = 1'b1;
		end else if (first_n == ddc_pkg::CODE_STAR) begin
			complete = size >= CODE_CNT;
		end else if (first_n == ddc_pkg::CODE_ZERO || first_n == ddc_pkg::CODE_ONE
			|| first_n == '0 || first_n == ddc_pkg::CODE_HASH) begin
			complete = 1'b1;
		end else begin
			complete = size >= NUM_CNT;
		end
	end

	always_comb begin
		rec.outcome          = outcome;
		rec.digit_count      = size;
		rec.address_complete = complete;
		rec.number_ok        = (size == NUM_CNT) && num_ok_n;
		rec.number_accum     = num_n;
		rec.code_ok          = (size == CODE_CNT) && code_ok_n;
		rec.code_accum       = code_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			first_q   <= '0;
			hash_q    <= 1'b0;
			num_q     <= '0;
			num_ok_q  <= 1'b1;
			code_q    <= '0;
			code_ok_q <= 1'b1;
		end else if (accept) begin
			cnt_q     <= cnt_n;
			first_q   <= first_n;
			hash_q    <= hash_n;
			num_q     <= num_n;
			num_ok_q  <= num_ok_n;
			code_q    <= code_n;
			code_ok_q <= code_ok_n;
		end
	end

endmodule

`default_nettype wire

/* rtl/ddc_fifo.sv */
// ----------------------------------------------------------------------------
// ddc_fifo
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire ddc_pkg::ddc_rec_t  wr_data,
	input  wire logic               rd_en,
	output ddc_pkg::ddc_rec_t       rd_data,
	output logic                    full,
	output logic                    avail
);

	ddc_pkg::ddc_rec_t                mem_q [ddc_pkg::FIFO_DEPTH];
	logic [ddc_pkg::FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [ddc_pkg::FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [ddc_pkg::FIFO_CNT_W-1:0]   cnt_q;

	assign full    = cnt_q == ddc_pkg::FIFO_CNT_W'(ddc_pkg::FIFO_DEPTH);
	assign avail   = cnt_q != '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + ddc_pkg::FIFO_PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + ddc_pkg::FIFO_PTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10: cnt_q <= cnt_q + ddc_pkg::FIFO_CNT_W'(1);
				2'b01: cnt_q <= cnt_q - ddc_pkg::FIFO_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/ddc_back.sv */
// ----------------------------------------------------------------------------
// ddc_back
// Holds the range registers, checks decoded values and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ddc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ddc_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                              rec_avail,
	input  wire ddc_pkg::ddc_rec_t                 rec,
	output logic                                   rec_take,
	input  wire logic                              pop,
	output logic                                   empty,
	output ddc_pkg::ddc_out_t                      result
);

	logic [ddc_pkg::NUM_W-1:0]  dn_min_q, dn_max_q;
	logic [ddc_pkg::CODE_W-1:0] sc_min_q, sc_max_q;
	logic                       out_valid_q;
	ddc_pkg::ddc_out_t          out_q;
	ddc_pkg::ddc_out_t          res;
	logic                       nvalid, cvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_min_q <= ddc_pkg::DN_MIN_RST;
			dn_max_q <= ddc_pkg::DN_MAX_RST;
			sc_min_q <= ddc_pkg::SC_MIN_RST;
			sc_max_q <= ddc_pkg::SC_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ddc_pkg::REG_DN_MIN: dn_min_q <= cfg_data[ddc_pkg::NUM_W-1:0];
				ddc_pkg::REG_DN_MAX: dn_max_q <= cfg_data[ddc_pkg::NUM_W-1:0];
				ddc_pkg::REG_SC_MIN: sc_min_q <= cfg_data[ddc_pkg::CODE_W-1:0];
				ddc_pkg::REG_SC_MAX: sc_max_q <= cfg_data[ddc_pkg::CODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign nvalid = rec.number_ok && rec.number_accum >= dn_min_q
		&& rec.number_accum <= dn_max_q;
	assign cvalid = rec.code_ok && rec.code_accum >= sc_min_q
		&& rec.code_accum <= sc_max_q;

	always_comb begin
		res.outcome          = rec.outcome;
		res.digit_count      = rec.digit_count;
		res.address_complete = rec.address_complete;
		res.number_valid     = nvalid;
		res.number_value     = nvalid ? rec.number_accum : '0;
		res.code_valid       = cvalid;
		res.code_value       = cvalid ? rec.code_accum : '0;
	end

	// refill the output register when it is free or being drained
	assign rec_take = rec_avail && (!out_valid_q || pop);
	assign empty    = !out_valid_q;
	assign result   = out_q;

	always_ff @(posedge clk) begin
		if (rec_take) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rec_take) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* rtl/dialed_digit_collector.sv */
// flow: an accepted request is written into the queue, and the back then moves
//   it into the output register when that register is free or being drained
// throughput: one request per cycle while the queue is not full; the front
//   computes the next digit state and the back checks ranges combinationally
// reset: arst_n clears the digit state, the queue and the output valid flag,
//   and loads the range registers with their default bounds
// ----------------------------------------------------------------------------
// dialed_digit_collector
// Collects dialed telephone digits and reports per-digit outcome, digit
// count, address completeness and decoded directory number / service code.
// ----------------------------------------------------------------------------
`default_nettype none

module dialed_digit_collector #(
	parameter int MAX_DIGITS    = 32,
	parameter int NUMBER_DIGITS = 7,
	parameter int CODE_DIGITS   = 3
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// request side
	input  wire logic                          push,
	output logic                               full,
	input  wire ddc_pkg::ddc_in_t              digit_req,
	// result side
	output logic                               empty,
	input  wire logic                          pop,
	output ddc_pkg::ddc_out_t                  result,
	// range registers
	input  wire logic                          cfg_we,
	input  wire logic [ddc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ddc_pkg::CFG_W-1:0]     cfg_data
);

	logic              accept;
	ddc_pkg::ddc_rec_t front_rec;
	ddc_pkg::ddc_rec_t head_rec;
	logic              head_avail;
	logic              head_take;

	// a request is taken whenever the queue has room
	assign accept = push && !full;

	// front: digit state, outcome and completeness
	ddc_front #(
		.MAX_DIGITS    (MAX_DIGITS),
		.NUMBER_DIGITS (NUMBER_DIGITS),
		.CODE_DIGITS   (CODE_DIGITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (digit_req),
		.rec    (front_rec)
	);

	// decouples front from a stalled result side
	ddc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (front_rec),
		.rd_en   (head_take),
		.rd_data (head_rec),
		.full    (full),
		.avail   (head_avail)
	);

	// back: range checks against the bound registers, output register
	ddc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rec_avail (head_avail),
		.rec       (head_rec),
		.rec_take  (head_take),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

`default_nettype wire

/* rtl/ddc_checker.sv */
// ----------------------------------------------------------------------------
// ddc_checker
// Port-level checks on the dialed digit collector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              push,
	input wire logic              full,
	input wire logic              empty,
	input wire logic              pop,
	input wire ddc_pkg::ddc_out_t result
);

	// the queue only fills while a result is waiting
	a_full_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("queue full with no result waiting");

	// no result appears without a request
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !(push && !full)) ##1 (empty && !(push && !full)) |=> empty)
		else $error("result appeared without a request");

	// a request into an idle block passes the queue and the output register and then shows on the result ports
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && empty |=> ##1 !empty)
		else $error("result did not arrive in time");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed or vanished");

endmodule

bind dialed_digit_collector ddc_checker u_ddc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

`default_nettype wire
